// ===== hdl/obm_pkg.sv =====
package obm_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned IdW    = 7;
  localparam int unsigned TloW   = 64;
  localparam int unsigned ThiW   = 56;
  localparam int unsigned AmtW   = 31;
  localparam int unsigned PriceW = 32;
  localparam int unsigned OidW   = 16;
  localparam int unsigned StW    = 2;
  localparam int unsigned TickChars = 15;

  localparam logic [StW-1:0] StOk   = 2'd0;
  localparam logic [StW-1:0] StFull = 2'd1;
  localparam logic [StW-1:0] StNoId = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_CLR  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SCAN_MATCH,
    SCAN_DEL,
    SCAN_CLR
  } scan_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_M,
    S_FILL,
    S_STORE,
    S_SCAN_D,
    S_MOVE_RD,
    S_MOVE_WR,
    S_CLR_SCAN,
    S_CLR_NEXT,
    S_CLR_WAIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             load_in;
    logic             scan_clear;
    logic             scan_run;
    scan_kind_e       scan_kind;
    logic             fill;
    logic             store;
    logic             move_rd;
    logic             move_wr;
    logic             clr_step;
    logic             res_load;
    logic [StW-1:0]   res_status;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic match_en;
    logic left_zero;
    logic full;
    logic count_zero;
    logic scan_done;
    logic best_v;
    logic found;
    logic fill_last;
    logic clr_done;
  } stat_t;

  // equal, or the same letter b..y in the other case
  function automatic logic chars_match(input logic [7:0] a, input logic [7:0] b);
    logic a_lo, a_up, b_lo, b_up;
    a_lo = (a > 8'h61) && (a < 8'h7a);
    a_up = (a > 8'h41) && (a < 8'h5a);
    b_lo = (b > 8'h61) && (b < 8'h7a);
    b_up = (b > 8'h41) && (b < 8'h5a);
    return (a == b) || (a_lo && b_up && (a == b + 8'd32)) ||
           (a_up && b_lo && (a + 8'd32 == b));
  endfunction

  function automatic logic ticker_match(input logic [TloW-1:0] alo, input logic [ThiW-1:0] ahi,
                                        input logic [TloW-1:0] blo, input logic [ThiW-1:0] bhi);
    logic [TickChars*8-1:0] a, b;
    logic ok;
    a  = {ahi, alo};
    b  = {bhi, blo};
    ok = 1'b1;
    for (int j = 0; j < TickChars; j++) begin
      ok = ok & chars_match(a[j*8 +: 8], b[j*8 +: 8]);
    end
    return ok;
  endfunction

endpackage

// ===== hdl/obm_ctrl.sv =====
module obm_ctrl
  import obm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e         state_q, state_d;
  logic [StW-1:0] st_q, st_d;
  logic           ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= StOk;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat_i.op)
          OP_ADD: begin
            if (stat_i.full) state_d = S_RESP;
            else if (stat_i.match_en && !stat_i.left_zero && !stat_i.count_zero)
              state_d = S_SCAN_M;
            else state_d = S_STORE;
          end
          OP_DEL:  state_d = S_SCAN_D;
          OP_CLR:  state_d = S_CLR_SCAN;
          default: state_d = S_RESP;
        endcase
      end
      S_SCAN_M:   if (stat_i.scan_done) state_d = stat_i.best_v ? S_FILL : S_STORE;
      S_FILL:     state_d = stat_i.fill_last ? S_STORE : S_SCAN_M;
      S_STORE:    state_d = S_RESP;
      S_SCAN_D: begin
        if (stat_i.scan_done) begin
          if (stat_i.found) state_d = S_MOVE_RD;
          else if (stat_i.op == OP_CLR) state_d = S_CLR_NEXT;
          else state_d = S_RESP;
        end
      end
      S_MOVE_RD:  state_d = S_MOVE_WR;
      S_MOVE_WR:  state_d = (stat_i.op == OP_CLR) ? S_CLR_NEXT : S_RESP;
      S_CLR_SCAN: if (stat_i.scan_done) state_d = S_CLR_NEXT;
      S_CLR_NEXT: state_d = stat_i.clr_done ? S_RESP : S_CLR_WAIT;
      S_CLR_WAIT: state_d = S_SCAN_D;
      S_RESP:     if (!ov_q || out_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.scan_kind  = SCAN_MATCH;
    cmd_o.res_status = st_q;
    st_d             = st_q;
    ov_d             = ov_q && !out_ready_i;
    in_ready_o       = (state_q == S_IDLE);
    out_valid_o      = ov_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) st_d = StOk;
      end
      S_DISPATCH: begin
        cmd_o.scan_clear = 1'b1;
        if (stat_i.op == OP_ADD && stat_i.full) st_d = StFull;
      end
      S_SCAN_M: begin
        cmd_o.scan_run  = 1'b1;
        cmd_o.scan_kind = SCAN_MATCH;
      end
      S_FILL: begin
        cmd_o.fill       = 1'b1;
        cmd_o.scan_clear = 1'b1;
      end
      S_STORE:    cmd_o.store = 1'b1;
      S_SCAN_D: begin
        cmd_o.scan_run  = 1'b1;
        cmd_o.scan_kind = SCAN_DEL;
        if (stat_i.scan_done && !stat_i.found && stat_i.op == OP_DEL) st_d = StNoId;
      end
      S_MOVE_RD:  cmd_o.move_rd = 1'b1;
      S_MOVE_WR:  cmd_o.move_wr = 1'b1;
      S_CLR_SCAN: begin
        cmd_o.scan_run  = 1'b1;
        cmd_o.scan_kind = SCAN_CLR;
      end
      S_CLR_NEXT: ;
      S_CLR_WAIT: begin
        cmd_o.clr_step   = 1'b1;
        cmd_o.scan_clear = 1'b1;
      end
      S_RESP: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          ov_d           = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/obm_dp.sv =====
module obm_dp
  import obm_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [1:0]        op_i,
  input  logic              match_enable_i,
  input  logic [TloW-1:0]   ticker_lo_i,
  input  logic [ThiW-1:0]   ticker_hi_i,
  input  logic              is_buy_i,
  input  logic [AmtW-1:0]   amount_i,
  input  logic [PriceW-1:0] price_cents_i,
  input  logic [OidW-1:0]   order_id_i,
  output logic [StW-1:0]    status_o,
  output logic [IdW-1:0]    assigned_id_o,
  output logic [AmtW-1:0]   remaining_o,
  output logic [IdW-1:0]    entry_total_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // entry stores
  logic [IdW-1:0]    id_mem    [DEPTH];
  logic [TloW-1:0]   tlo_mem   [DEPTH];
  logic [ThiW-1:0]   thi_mem   [DEPTH];
  logic              side_mem  [DEPTH];
  logic [AmtW-1:0]   amt_mem   [DEPTH];
  logic [PriceW-1:0] price_mem [DEPTH];
  logic [IdW-1:0]    lst_mem   [DEPTH];

  logic [IdW-1:0]    rd_id_q;
  logic [TloW-1:0]   rd_tlo_q;
  logic [ThiW-1:0]   rd_thi_q;
  logic              rd_side_q;
  logic [AmtW-1:0]   rd_amt_q;
  logic [PriceW-1:0] rd_price_q;
  logic [IdW-1:0]    lst_rd_q;

  // latched request
  op_e               op_q;
  logic              match_q, buy_q;
  logic [TloW-1:0]   tlo_q;
  logic [ThiW-1:0]   thi_q;
  logic [AmtW-1:0]   left_q, left_d;
  logic [PriceW-1:0] price_q;
  logic [OidW-1:0]   tgt_q, tgt_d;

  logic [CW-1:0]     count_q, count_d, sc_q, sc_d, ln_q, ln_d, k_q, k_d;
  logic              pv_q, pv_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic              best_v_q, best_v_d, found_q, found_d;
  logic [AW-1:0]     best_idx_q, best_idx_d, found_idx_q, found_idx_d;
  logic [PriceW-1:0] best_p_q, best_p_d;
  logic [AmtW-1:0]   best_amt_q, best_amt_d;
  logic [IdW-1:0]    asg_q, asg_d;
  logic [AmtW-1:0]   rem_q, rem_d;
  logic [StW-1:0]    res_st_q;
  logic [IdW-1:0]    res_tot_q;
  logic [IdW-1:0]    res_asg_q;
  logic [AmtW-1:0]   res_rem_q;

  logic              issue, elig, better, fill_big;
  logic [AW-1:0]     rd_addr, wr_addr, last_idx;
  logic [AmtW-1:0]   fill_amt;
  logic [IdW-1:0]    new_id;
  logic              lst_we;

  assign last_idx = AW'(count_q - CW'(1));
  assign issue    = cmd_i.scan_run && (sc_q != count_q);
  assign rd_addr  = cmd_i.move_rd ? last_idx : sc_q[AW-1:0];
  assign fill_big = left_q > best_amt_q;
  assign fill_amt = fill_big ? '0 : (best_amt_q - left_q);
  assign new_id   = IdW'(count_q + CW'(1));
  assign wr_addr  = cmd_i.store ? count_q[AW-1:0] :
                    cmd_i.move_wr ? found_idx_q : best_idx_q;

  assign elig   = (rd_side_q != buy_q) && (rd_amt_q != '0) &&
                  ticker_match(tlo_q, thi_q, rd_tlo_q, rd_thi_q) &&
                  (buy_q ? (price_q >= rd_price_q) : (price_q <= rd_price_q));
  assign better = !best_v_q || (buy_q ? (rd_price_q < best_p_q) : (rd_price_q >= best_p_q));
  assign lst_we = pv_q && (cmd_i.scan_kind == SCAN_CLR) && (rd_amt_q == '0);

  always_comb begin
    left_d      = left_q;
    tgt_d       = tgt_q;
    count_d     = count_q;
    sc_d        = issue ? sc_q + CW'(1) : sc_q;
    pv_d        = issue;
    pidx_d      = sc_q[AW-1:0];
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_p_d    = best_p_q;
    best_amt_d  = best_amt_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    ln_d        = lst_we ? ln_q + CW'(1) : ln_q;
    k_d         = cmd_i.clr_step ? k_q + CW'(1) : k_q;
    asg_d       = asg_q;
    rem_d       = rem_q;
    if (pv_q && cmd_i.scan_kind == SCAN_MATCH && elig && better) begin
      best_v_d   = 1'b1;
      best_idx_d = pidx_q;
      best_p_d   = rd_price_q;
      best_amt_d = rd_amt_q;
    end
    if (pv_q && cmd_i.scan_kind == SCAN_DEL && !found_q &&
        (OidW'(rd_id_q) == tgt_q)) begin
      found_d     = 1'b1;
      found_idx_d = pidx_q;
    end
    if (cmd_i.fill) left_d = fill_big ? (left_q - best_amt_q) : '0;
    if (cmd_i.store) begin
      count_d = count_q + CW'(1);
      asg_d   = new_id;
      rem_d   = left_q;
    end
    if (cmd_i.move_wr) count_d = count_q - CW'(1);
    if (cmd_i.clr_step) tgt_d = OidW'(lst_rd_q);
    if (cmd_i.scan_clear) begin
      sc_d     = '0;
      pv_d     = 1'b0;
      best_v_d = 1'b0;
      found_d  = 1'b0;
    end
    if (cmd_i.load_in) begin
      left_d = amount_i;
      tgt_d  = order_id_i;
      ln_d   = '0;
      k_d    = '0;
      asg_d  = '0;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sc_q     <= '0;
      pv_q     <= 1'b0;
      best_v_q <= 1'b0;
      found_q  <= 1'b0;
      ln_q     <= '0;
      k_q      <= '0;
    end else begin
      count_q  <= count_d;
      sc_q     <= sc_d;
      pv_q     <= pv_d;
      best_v_q <= best_v_d;
      found_q  <= found_d;
      ln_q     <= ln_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= op_e'(op_i);
      match_q <= match_enable_i;
      buy_q   <= is_buy_i;
      tlo_q   <= ticker_lo_i;
      thi_q   <= ticker_hi_i;
      price_q <= price_cents_i;
    end
    left_q      <= left_d;
    tgt_q       <= tgt_d;
    pidx_q      <= pidx_d;
    best_idx_q  <= best_idx_d;
    best_p_q    <= best_p_d;
    best_amt_q  <= best_amt_d;
    found_idx_q <= found_idx_d;
    asg_q       <= asg_d;
    rem_q       <= rem_d;
    if (cmd_i.res_load) begin
      res_st_q  <= cmd_i.res_status;
      res_tot_q <= IdW'(count_q);
      res_asg_q <= asg_q;
      res_rem_q <= rem_q;
    end
  end

  // stores: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store || cmd_i.move_wr) begin
      id_mem[wr_addr]    <= cmd_i.store ? new_id : rd_id_q;
      tlo_mem[wr_addr]   <= cmd_i.store ? tlo_q : rd_tlo_q;
      thi_mem[wr_addr]   <= cmd_i.store ? thi_q : rd_thi_q;
      side_mem[wr_addr]  <= cmd_i.store ? buy_q : rd_side_q;
      price_mem[wr_addr] <= cmd_i.store ? price_q : rd_price_q;
    end
    if (cmd_i.store || cmd_i.move_wr || cmd_i.fill) begin
      amt_mem[wr_addr] <= cmd_i.store ? left_q : (cmd_i.fill ? fill_amt : rd_amt_q);
    end
    rd_id_q    <= id_mem[rd_addr];
    rd_tlo_q   <= tlo_mem[rd_addr];
    rd_thi_q   <= thi_mem[rd_addr];
    rd_side_q  <= side_mem[rd_addr];
    rd_amt_q   <= amt_mem[rd_addr];
    rd_price_q <= price_mem[rd_addr];
  end

  // id list for clear
  always_ff @(posedge clk_i) begin
    if (lst_we) lst_mem[ln_q[AW-1:0]] <= rd_id_q;
    lst_rd_q <= lst_mem[k_q[AW-1:0]];
  end

  assign stat_o.op         = op_q;
  assign stat_o.match_en   = match_q;
  assign stat_o.left_zero  = (left_q == '0);
  assign stat_o.full       = (count_q == CW'(DEPTH));
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.scan_done  = (sc_q == count_q) && !pv_q;
  assign stat_o.best_v     = best_v_q;
  assign stat_o.found      = found_q;
  assign stat_o.fill_last  = !fill_big;
  assign stat_o.clr_done   = (k_q == ln_q);

  assign status_o      = res_st_q;
  assign assigned_id_o = res_asg_q;
  assign remaining_o   = res_rem_q;
  assign entry_total_o = res_tot_q;

endmodule

// ===== hdl/order_book_matcher_top.sv =====
// Flow, accept to result valid: an add without matching goes straight to store; a full-book add and
//   an unused op go straight to the result. A matching add scans the book once per pass and fills
//   the best entry found; the pass that finds nothing runs only when the order is not filled up.
// Delete scans for the id and moves the last entry into its slot. Clear scans for zero-amount
//   entries, then deletes each one in turn by its id. A stalled output adds its wait.
// Throughput: one transaction in flight; the next input is taken once the
//   result sits in the output register. Reset (async, active low) empties the book.
module order_book_matcher_top
  import obm_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input transaction
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // ticker_lo[63:0], ticker_hi[119:64], amount[150:120], price_cents[182:151],
  // order_id[198:183], zero pad [199]
  input  logic [199:0] s_axis_tdata_i,
  // op[1:0], match_enable[2], is_buy[3]
  input  logic [3:0]   s_axis_tuser_i,
  // result transaction
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[1:0], assigned_id[8:2], remaining[39:9], entry_total[46:40], zero pad [47]
  output logic [47:0]  m_axis_tdata_o
);

  cmd_t  cmd;
  stat_t stat;

  logic [StW-1:0]  status;
  logic [IdW-1:0]  assigned_id, entry_total;
  logic [AmtW-1:0] remaining;

  // sequencer: decides scans, fills, stores and moves
  obm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // book stores, scan pipeline and result registers
  obm_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (s_axis_tuser_i[1:0]),
    .match_enable_i (s_axis_tuser_i[2]),
    .ticker_lo_i    (s_axis_tdata_i[63:0]),
    .ticker_hi_i    (s_axis_tdata_i[119:64]),
    .is_buy_i       (s_axis_tuser_i[3]),
    .amount_i       (s_axis_tdata_i[150:120]),
    .price_cents_i  (s_axis_tdata_i[182:151]),
    .order_id_i     (s_axis_tdata_i[198:183]),
    .status_o       (status),
    .assigned_id_o  (assigned_id),
    .remaining_o    (remaining),
    .entry_total_o  (entry_total)
  );

  assign m_axis_tdata_o = {1'b0, entry_total, remaining, assigned_id, status};

endmodule

// ===== hdl/obm_checker.sv =====
module obm_checker
  import obm_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [47:0]  m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("undefined status code");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (DEPTH > 127) || (int'(m_axis_tdata_o[46:40]) <= DEPTH))
    else $error("entry total above depth");

endmodule

bind order_book_matcher_top obm_checker #(.DEPTH(DEPTH)) u_obm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== verif/tb.sv =====
module tb;
  import obm_pkg::*;

  localparam int unsigned Depth = DepthDefault;

  typedef struct packed {
    op_e              op;
    logic             match_en;
    logic [TloW-1:0]  tlo;
    logic [ThiW-1:0]  thi;
    logic             buy;
    logic [AmtW-1:0]  amt;
    logic [PriceW-1:0] price;
    logic [OidW-1:0]  oid;
  } order_req_t;

  // declared from the top bit down, status lands in the low bits
  typedef struct packed {
    logic [IdW-1:0]  total;
    logic [AmtW-1:0] rem;
    logic [IdW-1:0]  aid;
    logic [StW-1:0]  status;
  } book_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [199:0] s_axis_tdata_i = '0;
  logic [3:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;

  order_book_matcher_top #(.DEPTH(Depth)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // book mirror
  int unsigned     bk_n;
  logic [IdW-1:0]  bk_id   [Depth];
  logic [TloW-1:0] bk_tlo  [Depth];
  logic [ThiW-1:0] bk_thi  [Depth];
  logic            bk_side [Depth];
  logic [AmtW-1:0] bk_amt  [Depth];
  logic [PriceW-1:0] bk_px [Depth];

  order_req_t pending_q[$];
  book_resp_t resp_q[$];
  int errors = 0;
  int n_add = 0, n_fill = 0, n_full = 0, n_noid = 0, n_clr = 0;
  bit quiet = 0;      // no stalls at end
  bit hold_tx = 0;    // pressure pause

  function automatic bit ch_eq(logic [7:0] a, logic [7:0] b);
    bit al, au, bl, bu;
    al = a > "a" && a < "z"; au = a > "A" && a < "Z";
    bl = b > "a" && b < "z"; bu = b > "A" && b < "Z";
    return a == b || (al && bu && a == b + 8'd32) || (au && bl && a + 8'd32 == b);
  endfunction

  function automatic bit same_ticker(order_req_t r, int e);
    logic [119:0] a, b;
    a = {r.thi, r.tlo};
    b = {bk_thi[e], bk_tlo[e]};
    for (int j = 0; j < 15; j++)
      if (!ch_eq(a[j*8 +: 8], b[j*8 +: 8])) return 0;
    return 1;
  endfunction

  function automatic void drop_slot(int idx);
    int last;
    last = bk_n - 1;
    bk_id[idx] = bk_id[last]; bk_tlo[idx] = bk_tlo[last]; bk_thi[idx] = bk_thi[last];
    bk_side[idx] = bk_side[last]; bk_amt[idx] = bk_amt[last]; bk_px[idx] = bk_px[last];
    bk_n = last;
  endfunction

  function automatic bit drop_id(int unsigned id);
    for (int i = 0; i < bk_n; i++)
      if (bk_id[i] == id) begin
        drop_slot(i);
        return 1;
      end
    return 0;
  endfunction

  function automatic void take_fill(int e, ref logic [AmtW-1:0] left);
    n_fill++;
    if (left > bk_amt[e]) begin
      left -= bk_amt[e]; bk_amt[e] = 0;
    end else begin
      bk_amt[e] -= left; left = 0;
    end
  endfunction

  function automatic book_resp_t book_apply(order_req_t r);
    book_resp_t o;
    int lst[$];
    int ids[$];
    int v, k;
    logic [AmtW-1:0] left;
    o = '0;
    case (r.op)
      OP_ADD: begin
        if (bk_n >= Depth) begin
          o.status = StFull; n_full++;
        end else begin
          left = r.amt;
          if (r.match_en) begin
            for (int i = 0; i < bk_n; i++)
              if (bk_side[i] != r.buy && bk_amt[i] != 0 && same_ticker(r, i))
                lst.push_back(i);
            for (int i = 1; i < lst.size(); i++) begin
              v = lst[i]; k = i;
              while (k > 0 && bk_px[lst[k-1]] > bk_px[v]) begin
                lst[k] = lst[k-1]; k--;
              end
              lst[k] = v;
            end
            if (r.buy) begin
              for (int i = 0; i < lst.size(); i++)
                if (r.price >= bk_px[lst[i]]) begin
                  take_fill(lst[i], left);
                  if (left == 0) break;
                end
            end else begin
              for (int i = lst.size(); i > 0; i--)
                if (r.price <= bk_px[lst[i-1]]) begin
                  take_fill(lst[i-1], left);
                  if (left == 0) break;
                end
            end
          end
          o.aid = IdW'(bk_n + 1);
          bk_id[bk_n] = o.aid; bk_tlo[bk_n] = r.tlo; bk_thi[bk_n] = r.thi;
          bk_side[bk_n] = r.buy; bk_amt[bk_n] = left; bk_px[bk_n] = r.price;
          bk_n++;
          o.rem = left; n_add++;
        end
      end
      OP_DEL: if (!drop_id(r.oid)) begin
        o.status = StNoId; n_noid++;
      end
      OP_CLR: begin
        n_clr++;
        for (int i = 0; i < bk_n; i++)
          if (bk_amt[i] == 0) ids.push_back(bk_id[i]);
        foreach (ids[i]) void'(drop_id(ids[i]));
      end
      default: ;
    endcase
    o.total = IdW'(bk_n);
    return o;
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // accepted item leaves the queue here, so the head is always the next one
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        resp_q.push_back(book_apply(pending_q.pop_front()));
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          tx_gap <= $urandom_range(1, 9);
          s_axis_tvalid_i <= 1'b0;
        end else if (hold_tx || pending_q.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          order_req_t r;
          r = pending_q[0];
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {1'b0, r.oid, r.price, r.amt, r.thi, r.tlo};
          s_axis_tuser_i <= {r.buy, r.match_en, r.op};
        end
      end
    end
  end

  // monitor
  int rx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        book_resp_t got, exp_r;
        got = m_axis_tdata_o[46:0];
        if (resp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = resp_q.pop_front();
          if (got != exp_r) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st=%0d id=%0d rem=%0d tot=%0d got st=%0d id=%0d rem=%0d tot=%0d",
                       exp_r.status, exp_r.aid, exp_r.rem, exp_r.total,
                       got.status, got.aid, got.rem, got.total);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_gap <= $urandom_range(1, 9);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ticker pool, case variants exercise folding
  function automatic order_req_t mk(op_e op, bit m, logic [TloW-1:0] lo, logic [ThiW-1:0] hi,
                                    bit b, logic [AmtW-1:0] a, logic [PriceW-1:0] p,
                                    logic [OidW-1:0] id);
    order_req_t r;
    r.op = op; r.match_en = m; r.tlo = lo; r.thi = hi; r.buy = b;
    r.amt = a; r.price = p; r.oid = id;
    return r;
  endfunction

  function automatic logic [TloW-1:0] pick_tick();
    case ($urandom_range(0, 5))
      0: return "LPA";     // stored byte order reversed; fine for matching
      1: return "lpa";
      2: return "Zaz";
      3: return "zAZ";
      4: return "BbY";
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    order_req_t r;
    int unsigned sel;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_q.push_back(mk(OP_DEL, 0, 0, 0, 0, 0, 0, 16'hffff));            // empty delete
    pending_q.push_back(mk(OP_CLR, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(OP_NONE, 1, '1, '1, 1, '1, '1, '1));
    pending_q.push_back(mk(OP_ADD, 1, "abz", 0, 0, 100, 500, 0));
    pending_q.push_back(mk(OP_ADD, 1, "ABZ", 0, 0, 50, 400, 0));
    pending_q.push_back(mk(OP_ADD, 1, "aBz", 0, 1, 120, 450, 0));
    pending_q.push_back(mk(OP_ADD, 1, "abz", 0, 1, 200, 600, 0));
    pending_q.push_back(mk(OP_ADD, 1, "xyz", '1, 1, '1, '1, 0));
    pending_q.push_back(mk(OP_ADD, 1, "XYZ", '1, 0, 10, 0, 0));
    pending_q.push_back(mk(OP_ADD, 0, "XYZ", '1, 0, 0, '1, 0));
    pending_q.push_back(mk(OP_ADD, 1, '1, '1, 1, 1, 0, 0));
    pending_q.push_back(mk(OP_DEL, 0, 0, 0, 0, 0, 0, 16'd2));
    pending_q.push_back(mk(OP_DEL, 0, 0, 0, 0, 0, 0, 16'd130));            // high bits set
    pending_q.push_back(mk(OP_CLR, 0, 0, 0, 0, 0, 0, 0));
    while (pending_q.size() || resp_q.size()) @(posedge clk_i);
    // sender pause after drain
    hold_tx = 1;
    repeat (20) @(posedge clk_i);
    hold_tx = 0;
    // fill book to full, store only
    repeat (Depth + 2) pending_q.push_back(mk(OP_ADD, 0, pick_tick(), 0, $urandom_range(0, 1),
                                              $urandom_range(0, 3), $urandom_range(0, 9), 0));
    pending_q.push_back(mk(OP_CLR, 0, 0, 0, 0, 0, 0, 0));
    // random traffic
    for (int i = 0; i < 60; i++) begin
      sel = $urandom_range(0, 19);
      r = mk(OP_ADD, $urandom_range(0, 7) != 0, pick_tick(),
             $urandom_range(0, 15) == 0 ? {$urandom, $urandom} : 0,
             $urandom_range(0, 1),
             $urandom_range(0, 7) == 0 ? {$urandom} : $urandom_range(0, 300),
             $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(100, 140),
             $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 70));
      if (sel < 3) r.op = OP_DEL;
      else if (sel == 3) r.op = OP_CLR;
      else if (sel == 4) r.op = OP_NONE;
      if (i == 45) begin
        while (pending_q.size() || resp_q.size()) @(posedge clk_i);
        quiet = 1;
      end
      pending_q.push_back(r);
    end
    while (pending_q.size() || resp_q.size()) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("book ran %0d adds, %0d fills, %0d full refusals, %0d unknown ids, %0d clears",
             n_add, n_fill, n_full, n_noid, n_clr);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
